/* design/dht_pkg.sv */
// dht_pkg: shared types and constants of the double-hashing table
`timescale 1ns / 1ps

package dht_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned MARK_W     = 2;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned DIV_W      = 17;
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIV_CNT_W  = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 16'd1007;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_STEP,
    S_RED,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIV_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

/* design/dht_in_if.sv */
// dht_in_if: request channel carrying opcode, key and value
`timescale 1ns / 1ps

interface dht_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [31:0]            key;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

/* design/dht_out_if.sv */
// dht_out_if: response channel carrying status and read value
`timescale 1ns / 1ps

interface dht_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [VALUE_WIDTH-1:0] read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink   (input valid, input status, input read_value, output ready);
endinterface

/* design/dht_mod_unit.sv */
// dht_mod_unit: iterative remainder unit, two quotient bits per cycle
`timescale 1ns / 1ps

module dht_mod_unit
  import dht_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]      div_q, div_d;
  logic [DIV_W-1:0]      rem_q, rem_d;

  logic [DIV_W:0]   r1, r2;
  logic [DIV_W-1:0] r1n, r2n;

  always_comb begin
    // two restoring steps per cycle
    r1  = {rem_q, dvd_q[DIVIDEND_W-1]};
    r1n = (r1 >= {1'b0, div_q}) ? DIV_W'(r1 - {1'b0, div_q}) : r1[DIV_W-1:0];
    r2  = {r1n, dvd_q[DIVIDEND_W-2]};
    r2n = (r2 >= {1'b0, div_q}) ? DIV_W'(r2 - {1'b0, div_q}) : r2[DIV_W-1:0];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (!busy_q && req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = r2n;
      dvd_d = {dvd_q[DIVIDEND_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* design/dht_slot_mem.sv */
// dht_slot_mem: slot store, one write and one registered read per cycle
`timescale 1ns / 1ps

module dht_slot_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned WORD_W = 66
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dht_ctrl.sv */
// dht_ctrl: sequencer for hashing, probing and result delivery
`timescale 1ns / 1ps

module dht_ctrl
  import dht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IDX_W       = 10,
  parameter int unsigned WORD_W      = 66
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DIV_W-1:0]  step_div_i,
  dht_in_if.sink            in_if,
  dht_out_if.source         out_if,
  output div_req_t          div_req_o,
  input  div_rsp_t          div_rsp_i,
  output logic              mem_we_o,
  output logic [IDX_W-1:0]  mem_waddr_o,
  output logic [WORD_W-1:0] mem_wdata_o,
  output logic [IDX_W-1:0]  mem_raddr_o,
  input  logic [WORD_W-1:0] mem_rdata_i
);

  localparam logic [DIV_W-1:0] DEPTH_DIV  = DIV_W'(TABLE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_SUM  = (IDX_W+1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  // power-of-two depth: remainders by the depth are plain bit masks
  localparam bit               DEPTH_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  state_e state_q, state_d;

  logic [OP_W-1:0]        op_q, op_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       step_q, step_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [STATUS_W-1:0]    res_st_q, res_st_d;
  logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_st_q, out_st_d;
  logic [VALUE_WIDTH-1:0] out_val_q, out_val_d;

  logic [IDX_W:0]         sum;
  logic [IDX_W-1:0]       idx_nxt;
  logic [DIV_W-1:0]       step_full;
  logic [MARK_W-1:0]      rd_mark;
  logic [KEY_W-1:0]       rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   hit;

  assign rd_mark = mem_rdata_i[WORD_W-1 -: MARK_W];
  assign rd_key  = mem_rdata_i[VALUE_WIDTH +: KEY_W];
  assign rd_val  = mem_rdata_i[VALUE_WIDTH-1:0];

  // next probe slot, both terms below the depth
  assign sum     = {1'b0, idx_q} + {1'b0, step_q};
  assign idx_nxt = (sum >= DEPTH_SUM) ? IDX_W'(sum - DEPTH_SUM) : sum[IDX_W-1:0];

  assign step_full = step_div_i - div_rsp_i.rem;
  assign hit       = (rd_mark == MARK_LIVE) && (rd_key == key_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    res_st_d    = res_st_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_st_d    = out_st_q;
    out_val_d   = out_val_q;

    div_req_o   = '{start: 1'b0, dividend: '0, divisor: DEPTH_DIV};
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = {MARK_EMPTY, key_q, val_q};
    mem_raddr_o = idx_q;
    in_if.ready = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = '0;
        idx_d       = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          op_d      = in_if.opcode;
          key_d     = in_if.key;
          val_d     = in_if.value;
          cnt_d     = '0;
          res_val_d = '0;
          if (in_if.opcode == OP_UNUSED) begin
            res_st_d = ST_MISSING;
            state_d  = S_DONE;
          end else if (DEPTH_POW2) begin
            idx_d     = in_if.key[IDX_W-1:0];
            div_req_o = '{start: 1'b1, dividend: in_if.key, divisor: step_div_i};
            state_d   = S_STEP;
          end else begin
            div_req_o = '{start: 1'b1, dividend: in_if.key, divisor: DEPTH_DIV};
            state_d   = S_HOME;
          end
        end
      end
      S_HOME: begin
        if (div_rsp_i.done) begin
          idx_d     = div_rsp_i.rem[IDX_W-1:0];
          div_req_o = '{start: 1'b1, dividend: key_q, divisor: step_div_i};
          state_d   = S_STEP;
        end
      end
      S_STEP: begin
        if (div_rsp_i.done) begin
          if (step_full < DEPTH_DIV) begin
            step_d  = step_full[IDX_W-1:0];
            state_d = S_READ;
          end else if (DEPTH_POW2) begin
            step_d  = step_full[IDX_W-1:0];
            state_d = S_READ;
          end else begin
            div_req_o = '{start: 1'b1, dividend: DIVIDEND_W'(step_full),
                          divisor: DEPTH_DIV};
            state_d   = S_RED;
          end
        end
      end
      S_RED: begin
        if (div_rsp_i.done) begin
          step_d  = div_rsp_i.rem[IDX_W-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        mem_raddr_o = idx_nxt;
        if ((op_q == OP_INSERT) && (rd_mark != MARK_LIVE)) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = {MARK_LIVE, key_q, val_q};
          res_st_d    = ST_OK;
          state_d     = S_DONE;
        end else if ((op_q != OP_INSERT) && (rd_mark == MARK_EMPTY)) begin
          res_st_d = ST_MISSING;
          state_d  = S_DONE;
        end else if ((op_q != OP_INSERT) && hit) begin
          res_st_d = ST_OK;
          state_d  = S_DONE;
          if (op_q == OP_REMOVE) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = {MARK_DELETED, rd_key, rd_val};
          end else begin
            res_val_d = rd_val;
          end
        end else if (cnt_q == LAST_IDX) begin
          res_st_d = (op_q == OP_INSERT) ? ST_FULL : ST_MISSING;
          state_d  = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
          idx_d = idx_nxt;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_val_d   = res_val_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    val_q     <= val_d;
    step_q    <= step_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    out_st_q  <= out_st_d;
    out_val_q <= out_val_d;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.status     = out_st_q;
  assign out_if.read_value = out_val_q;

endmodule

/* design/double_hash_table_top.sv */
// double_hash_table_top: open-addressing hash table with double hashing
`timescale 1ns / 1ps
//
// channel  | dir | payload                       | transfer when
// ---------+-----+-------------------------------+--------------------------
// in_if    | in  | opcode, key, value            | in_if.valid & in_if.ready
// out_if   | out | status, read_value            | out_if.valid & out_if.ready
// cfg      | in  | cfg_wdata_i (step divisor)    | cfg_we_i
//
// after reset the slot store is swept to empty with in_if.ready low; key mod divisor
// runs on the shared remainder unit in 16 steps, then a read state, one check state per
// probe and a load into the result register; in_if.ready is high only in idle; a non
// power-of-two depth adds a remainder pass for the home slot and one when the step
// reaches the depth; an unused opcode answers missing without probing; a stalled out_if
// holds the result register; the next item runs and then waits in done

module double_hash_table_top
  import dht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  dht_in_if.sink           in_if,
  dht_out_if.source        out_if
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W = MARK_W + KEY_W + VALUE_WIDTH;

  // step divisor register, zero reads as 65536
  logic [CFG_W-1:0] step_div_q;
  logic [DIV_W-1:0] step_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_div_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      step_div_q <= cfg_wdata_i;
    end
  end

  assign step_div = (step_div_q == '0) ? {1'b1, {CFG_W{1'b0}}} : {1'b0, step_div_q};

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // shared remainder unit for the step, and for home slot and step reduction
  // when the depth is not a power of two
  dht_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // mark, key and value of each slot in one word
  dht_slot_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W),
    .WORD_W (WORD_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer: clear sweep, hashing, probe loop, result register
  dht_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W),
    .WORD_W      (WORD_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_div_i  (step_div),
    .in_if       (in_if),
    .out_if      (out_if),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule
